FILE: sv/wlqe_pkg.sv
// ----------------------------------------------------------------------------
// wlqe_pkg
// Shared widths, the sideband record and helpers for the wide line expander.
// ----------------------------------------------------------------------------
package wlqe_pkg;

  localparam int FRAC_BITS   = 4;
  localparam int COORD_BITS  = 20;
  localparam int WIDTH_BITS  = 16;
  localparam int COLOR_BITS  = 32;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int MAG_BITS    = COORD_BITS;
  localparam int EXT_BITS    = WIDTH_BITS + 1;
  localparam int PROD_BITS   = MAG_BITS + EXT_BITS;
  localparam int SQ_BITS     = 2 * MAG_BITS;
  localparam int LEN_EXTRA   = 10;
  localparam int RAD_BITS    = SQ_BITS + 2 + 2 * LEN_EXTRA;
  localparam int ROOT_BITS   = RAD_BITS / 2;
  localparam int DEN_BITS    = ROOT_BITS + 1;
  localparam int NUM_BITS    = PROD_BITS + LEN_EXTRA + 2;
  localparam int QUO_BITS    = EXT_BITS + 1;
  localparam int OFS_BITS    = EXT_BITS + 1;
  localparam int CORNER_BITS = COORD_BITS + 2;
  localparam int SLOT_BITS   = 3;
  localparam int NUM_SLOTS   = 6;
  localparam int NUM_CORNERS = 4;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [WIDTH_BITS-1:0] hw;
    logic [COLOR_BITS-1:0] color;
    logic                  negx;
    logic                  negy;
    logic                  zero;
    logic [EXT_BITS-1:0]   ext;
    logic [PROD_BITS-1:0]  mx;
    logic [PROD_BITS-1:0]  my;
  } side_t;

  // slots 0..5 use corners 0,1,2,1,2,3
  function automatic logic [1:0] corner_of_slot(input logic [SLOT_BITS-1:0] slot);
    logic [1:0] c;
    case (slot)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd2;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [CORNER_BITS-1:0] v);
    logic signed [CORNER_BITS-1:0] hi;
    logic signed [CORNER_BITS-1:0] lo;
    logic [COORD_BITS-1:0] r;
    hi = CORNER_BITS'((1 << (COORD_BITS - 1)) - 1);
    lo = -hi - CORNER_BITS'(1);
    if (v > hi) r = hi[COORD_BITS-1:0];
    else if (v < lo) r = lo[COORD_BITS-1:0];
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

endpackage

FILE: sv/wlqe_sqrt_cell.sv
// ----------------------------------------------------------------------------
// wlqe_sqrt_cell
// One root bit of a restoring square root; hands remainder and root onward.
// ----------------------------------------------------------------------------
module wlqe_sqrt_cell import wlqe_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_BITS-1:0]  in_rem,
  input  logic [ROOT_BITS-1:0] in_root,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic [RAD_BITS-1:0]  out_rem,
  output logic [ROOT_BITS-1:0] out_root,
  output side_t                out_side
);

  localparam int TW = RAD_BITS + 1;

  logic [TW-1:0] trial;
  logic          take;

  // (2q + 2^b) * 2^b, lower root bits are still zero so the add is an or
  assign trial = ({{(TW-ROOT_BITS){1'b0}}, in_root} << (BIT + 1)) |
                 ({{(TW-1){1'b0}}, 1'b1} << (2 * BIT));
  assign take  = ({1'b0, in_rem} >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= take ? (in_rem - trial[RAD_BITS-1:0]) : in_rem;
    out_root <= take ? (in_root | ({{(ROOT_BITS-1){1'b0}}, 1'b1} << BIT)) : in_root;
    out_side <= in_side;
  end

endmodule

FILE: sv/wlqe_div_cell.sv
// ----------------------------------------------------------------------------
// wlqe_div_cell
// One quotient bit of two restoring divisions sharing a divisor.
// ----------------------------------------------------------------------------
module wlqe_div_cell import wlqe_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [DEN_BITS-1:0] in_den,
  input  logic [NUM_BITS-1:0] in_remx,
  input  logic [NUM_BITS-1:0] in_remy,
  input  logic [QUO_BITS-1:0] in_qx,
  input  logic [QUO_BITS-1:0] in_qy,
  input  side_t               in_side,
  output logic                out_valid,
  output logic [DEN_BITS-1:0] out_den,
  output logic [NUM_BITS-1:0] out_remx,
  output logic [NUM_BITS-1:0] out_remy,
  output logic [QUO_BITS-1:0] out_qx,
  output logic [QUO_BITS-1:0] out_qy,
  output side_t               out_side
);

  localparam int TW = NUM_BITS + 1;

  logic [TW-1:0]       trial;
  logic                takex;
  logic                takey;
  logic [QUO_BITS-1:0] qbit;

  assign trial = {{(TW-DEN_BITS){1'b0}}, in_den} << BIT;
  assign takex = ({1'b0, in_remx} >= trial);
  assign takey = ({1'b0, in_remy} >= trial);
  assign qbit  = {{(QUO_BITS-1){1'b0}}, 1'b1} << BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_den  <= in_den;
    out_remx <= takex ? (in_remx - trial[NUM_BITS-1:0]) : in_remx;
    out_remy <= takey ? (in_remy - trial[NUM_BITS-1:0]) : in_remy;
    out_qx   <= takex ? (in_qx | qbit) : in_qx;
    out_qy   <= takey ? (in_qy | qbit) : in_qy;
    out_side <= in_side;
  end

endmodule

FILE: sv/wlqe_vertex_out.sv
// ----------------------------------------------------------------------------
// wlqe_vertex_out
// Holds the four corners of one segment and steps out its six vertices.
// ----------------------------------------------------------------------------
module wlqe_vertex_out import wlqe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [COORD_BITS-1:0] load_cx [NUM_CORNERS],
  input  logic [COORD_BITS-1:0] load_cy [NUM_CORNERS],
  input  side_t                 load_side,
  output logic                  vertex_valid,
  output logic [COORD_BITS-1:0] corner_x,
  output logic [COORD_BITS-1:0] corner_y,
  output logic [COORD_BITS-1:0] seg_start_x,
  output logic [COORD_BITS-1:0] seg_start_y,
  output logic [COORD_BITS-1:0] seg_end_x,
  output logic [COORD_BITS-1:0] seg_end_y,
  output logic [COLOR_BITS-1:0] vertex_color,
  output logic [WIDTH_BITS-1:0] vertex_width,
  output logic [SLOT_BITS-1:0]  vertex_slot,
  output logic                  last_vertex
);

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);

  logic                  active;
  logic [SLOT_BITS-1:0]  slot;
  logic [COORD_BITS-1:0] cx [NUM_CORNERS];
  logic [COORD_BITS-1:0] cy [NUM_CORNERS];
  side_t                 side;
  logic [1:0]            sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      slot   <= '0;
    end else if (load) begin
      active <= 1'b1;
      slot   <= '0;
    end else if (active) begin
      if (slot == LAST_SLOT) begin
        active <= 1'b0;
      end
      slot <= slot + SLOT_BITS'(1);
    end
    if (load) begin
      cx   <= load_cx;
      cy   <= load_cy;
      side <= load_side;
    end
  end

  assign sel          = corner_of_slot(slot);
  assign vertex_valid = active;
  assign corner_x     = cx[sel];
  assign corner_y     = cy[sel];
  assign seg_start_x  = side.sx;
  assign seg_start_y  = side.sy;
  assign seg_end_x    = side.ex;
  assign seg_end_y    = side.ey;
  assign vertex_color = side.color;
  assign vertex_width = side.hw;
  assign vertex_slot  = slot;
  assign last_vertex  = (slot == LAST_SLOT);

endmodule

FILE: sv/wide_line_quad_expander_core.sv
// ----------------------------------------------------------------------------
// wide_line_quad_expander_core
// Expands a wide line segment into six triangle-list vertices.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  segment  | start, busy           | start_x/y, end_x/y, line_radius, color
//  vertex   | vertex_valid          | corner_x/y, seg_*, vertex_color/width,
//           |                       | vertex_slot, last_vertex
//
// the vertex port sends one vertex per cycle; busy spaces the segments so that
// their vertices do not overlap. a segment runs through a chain of 31 square
// root cells and 18 divider cells plus 7 other stages; busy goes high after
// each accepted segment.
// synchronous reset empties the chain; no result can be stalled.
// ----------------------------------------------------------------------------
module wide_line_quad_expander_core import wlqe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [WIDTH_BITS-1:0] line_radius,
  input  logic [COLOR_BITS-1:0] line_color,
  output logic                  vertex_valid,
  output logic [COORD_BITS-1:0] corner_x,
  output logic [COORD_BITS-1:0] corner_y,
  output logic [COORD_BITS-1:0] seg_start_x,
  output logic [COORD_BITS-1:0] seg_start_y,
  output logic [COORD_BITS-1:0] seg_end_x,
  output logic [COORD_BITS-1:0] seg_end_y,
  output logic [COLOR_BITS-1:0] vertex_color,
  output logic [WIDTH_BITS-1:0] vertex_width,
  output logic [SLOT_BITS-1:0]  vertex_slot,
  output logic                  last_vertex
);

  localparam int GAP_BITS = 3;
  localparam logic [GAP_BITS-1:0] GAP = GAP_BITS'(NUM_SLOTS - 1);

  logic [GAP_BITS-1:0] gap;
  logic                accept;

  assign accept = start && !busy;
  assign busy   = (gap != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (accept) begin
      gap <= GAP;
    end else if (gap != '0) begin
      gap <= gap - GAP_BITS'(1);
    end
  end

  // stage 0: capture
  logic  v0;
  side_t s0;
  side_t s0_next;

  always_comb begin
    s0_next       = '0;
    s0_next.sx    = start_x;
    s0_next.sy    = start_y;
    s0_next.ex    = end_x;
    s0_next.ey    = end_y;
    s0_next.hw    = line_radius;
    s0_next.color = line_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    if (accept) begin
      s0 <= s0_next;
    end
  end

  // stage 1: differences and magnitudes
  logic [DIFF_BITS-1:0] dx;
  logic [DIFF_BITS-1:0] dy;
  logic [DIFF_BITS-1:0] adx;
  logic [DIFF_BITS-1:0] ady;
  logic                 v1;
  side_t                s1;
  side_t                s1_next;
  logic [MAG_BITS-1:0]  ax;
  logic [MAG_BITS-1:0]  ay;

  assign dx  = {s0.ex[COORD_BITS-1], s0.ex} - {s0.sx[COORD_BITS-1], s0.sx};
  assign dy  = {s0.ey[COORD_BITS-1], s0.ey} - {s0.sy[COORD_BITS-1], s0.sy};
  assign adx = dx[DIFF_BITS-1] ? -dx : dx;
  assign ady = dy[DIFF_BITS-1] ? -dy : dy;

  always_comb begin
    s1_next      = s0;
    s1_next.negx = dx[DIFF_BITS-1];
    s1_next.negy = dy[DIFF_BITS-1];
    s1_next.zero = (dx == '0) && (dy == '0);
    s1_next.ext  = {1'b0, s0.hw} + EXT_BITS'(1 << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    s1 <= s1_next;
    ax <= adx[MAG_BITS-1:0];
    ay <= ady[MAG_BITS-1:0];
  end

  // stage 2: squares and scaled magnitudes
  logic               v2;
  side_t              s2;
  side_t              s2_next;
  logic [SQ_BITS-1:0] sqx;
  logic [SQ_BITS-1:0] sqy;

  always_comb begin
    s2_next    = s1;
    s2_next.mx = {{EXT_BITS{1'b0}}, ax} * {{MAG_BITS{1'b0}}, s1.ext};
    s2_next.my = {{EXT_BITS{1'b0}}, ay} * {{MAG_BITS{1'b0}}, s1.ext};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2  <= s2_next;
    sqx <= {{MAG_BITS{1'b0}}, ax} * {{MAG_BITS{1'b0}}, ax};
    sqy <= {{MAG_BITS{1'b0}}, ay} * {{MAG_BITS{1'b0}}, ay};
  end

  // stage 3: radicand, length squared with extra fraction bits
  logic                v3;
  side_t               s3;
  logic [RAD_BITS-1:0] rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3  <= s2;
    rad <= {1'b0, ({1'b0, sqx} + {1'b0, sqy}), {(2 * LEN_EXTRA){1'b0}}};
  end

  // square root chain
  logic                 sq_v    [ROOT_BITS+1];
  logic [RAD_BITS-1:0]  sq_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sq_root [ROOT_BITS+1];
  side_t                sq_side [ROOT_BITS+1];

  assign sq_v[0]    = v3;
  assign sq_rem[0]  = rad;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
    wlqe_sqrt_cell #(.BIT(ROOT_BITS - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_valid(sq_v[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // stage 4: rounded division setup, q = (2 num + len) / (2 len)
  logic                v4;
  side_t               s4;
  logic [DEN_BITS-1:0] den;
  logic [NUM_BITS-1:0] numx;
  logic [NUM_BITS-1:0] numy;
  logic [ROOT_BITS-1:0] len;

  assign len = sq_root[ROOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= sq_v[ROOT_BITS];
    end
    s4   <= sq_side[ROOT_BITS];
    den  <= {len, 1'b0};
    numx <= {1'b0, sq_side[ROOT_BITS].mx, {(LEN_EXTRA + 1){1'b0}}} +
            {{(NUM_BITS-ROOT_BITS){1'b0}}, len};
    numy <= {1'b0, sq_side[ROOT_BITS].my, {(LEN_EXTRA + 1){1'b0}}} +
            {{(NUM_BITS-ROOT_BITS){1'b0}}, len};
  end

  // divider chain
  logic                dv_v    [QUO_BITS+1];
  logic [DEN_BITS-1:0] dv_den  [QUO_BITS+1];
  logic [NUM_BITS-1:0] dv_remx [QUO_BITS+1];
  logic [NUM_BITS-1:0] dv_remy [QUO_BITS+1];
  logic [QUO_BITS-1:0] dv_qx   [QUO_BITS+1];
  logic [QUO_BITS-1:0] dv_qy   [QUO_BITS+1];
  side_t               dv_side [QUO_BITS+1];

  assign dv_v[0]    = v4;
  assign dv_den[0]  = den;
  assign dv_remx[0] = numx;
  assign dv_remy[0] = numy;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_side[0] = s4;

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    wlqe_div_cell #(.BIT(QUO_BITS - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_v[i]),
      .in_den   (dv_den[i]),
      .in_remx  (dv_remx[i]),
      .in_remy  (dv_remy[i]),
      .in_qx    (dv_qx[i]),
      .in_qy    (dv_qy[i]),
      .in_side  (dv_side[i]),
      .out_valid(dv_v[i+1]),
      .out_den  (dv_den[i+1]),
      .out_remx (dv_remx[i+1]),
      .out_remy (dv_remy[i+1]),
      .out_qx   (dv_qx[i+1]),
      .out_qy   (dv_qy[i+1]),
      .out_side (dv_side[i+1])
    );
  end

  // stage 5: clamp to the extension and apply direction signs
  side_t               dq_side;
  logic [QUO_BITS-1:0] qx;
  logic [QUO_BITS-1:0] qy;
  logic [EXT_BITS-1:0] magx;
  logic [EXT_BITS-1:0] magy;
  logic                v5;
  side_t               s5;
  logic [OFS_BITS-1:0] ox;
  logic [OFS_BITS-1:0] oy;

  assign dq_side = dv_side[QUO_BITS];
  assign qx      = dv_qx[QUO_BITS];
  assign qy      = dv_qy[QUO_BITS];
  assign magx    = (qx > {1'b0, dq_side.ext}) ? dq_side.ext : qx[EXT_BITS-1:0];
  assign magy    = (qy > {1'b0, dq_side.ext}) ? dq_side.ext : qy[EXT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= dv_v[QUO_BITS];
    end
    s5 <= dq_side;
    ox <= dq_side.negx ? -{1'b0, magx} : {1'b0, magx};
    oy <= dq_side.negy ? -{1'b0, magy} : {1'b0, magy};
  end

  // corners, then saturate into the vertex stage
  logic signed [CORNER_BITS-1:0] psx;
  logic signed [CORNER_BITS-1:0] psy;
  logic signed [CORNER_BITS-1:0] pex;
  logic signed [CORNER_BITS-1:0] pey;
  logic signed [CORNER_BITS-1:0] pox;
  logic signed [CORNER_BITS-1:0] poy;
  logic signed [CORNER_BITS-1:0] pw;
  logic signed [CORNER_BITS-1:0] wx [NUM_CORNERS];
  logic signed [CORNER_BITS-1:0] wy [NUM_CORNERS];
  logic [COORD_BITS-1:0]         sat_x [NUM_CORNERS];
  logic [COORD_BITS-1:0]         sat_y [NUM_CORNERS];

  assign psx = {{(CORNER_BITS-COORD_BITS){s5.sx[COORD_BITS-1]}}, s5.sx};
  assign psy = {{(CORNER_BITS-COORD_BITS){s5.sy[COORD_BITS-1]}}, s5.sy};
  assign pex = {{(CORNER_BITS-COORD_BITS){s5.ex[COORD_BITS-1]}}, s5.ex};
  assign pey = {{(CORNER_BITS-COORD_BITS){s5.ey[COORD_BITS-1]}}, s5.ey};
  assign pox = {{(CORNER_BITS-OFS_BITS){ox[OFS_BITS-1]}}, ox};
  assign poy = {{(CORNER_BITS-OFS_BITS){oy[OFS_BITS-1]}}, oy};
  assign pw  = {{(CORNER_BITS-WIDTH_BITS){1'b0}}, s5.hw};

  always_comb begin
    if (s5.zero) begin
      // degenerate segment: plain square of half width, no extra pixel
      wx[0] = psx + pw;  wy[0] = psy + pw;
      wx[1] = psx + pw;  wy[1] = psy - pw;
      wx[2] = psx - pw;  wy[2] = psy + pw;
      wx[3] = psx - pw;  wy[3] = psy - pw;
    end else begin
      wx[0] = psx - pox - poy;  wy[0] = psy - poy + pox;
      wx[1] = pex + pox - poy;  wy[1] = pey + poy + pox;
      wx[2] = psx - pox + poy;  wy[2] = psy - poy - pox;
      wx[3] = pex + pox + poy;  wy[3] = pey + poy - pox;
    end
    for (int k = 0; k < NUM_CORNERS; k++) begin
      sat_x[k] = sat_coord(wx[k]);
      sat_y[k] = sat_coord(wy[k]);
    end
  end

  wlqe_vertex_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (v5),
    .load_cx     (sat_x),
    .load_cy     (sat_y),
    .load_side   (s5),
    .vertex_valid(vertex_valid),
    .corner_x    (corner_x),
    .corner_y    (corner_y),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .vertex_color(vertex_color),
    .vertex_width(vertex_width),
    .vertex_slot (vertex_slot),
    .last_vertex (last_vertex)
  );

endmodule

FILE: test/tb_wide_line_quad_expander_core.sv
// ----------------------------------------------------------------------------
// tb_wide_line_quad_expander_core
// Sends line segments through the quad expander and checks all six vertices
// of each one against a fixed point predictor of the offset arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_wide_line_quad_expander_core;
  import wlqe_pkg::*;

  typedef struct {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COLOR_BITS-1:0] color;
    logic [WIDTH_BITS-1:0] hw;
    logic [SLOT_BITS-1:0]  slot;
    logic                  last;
  } vertex_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_BITS-1:0] start_x = '0;
  logic [COORD_BITS-1:0] start_y = '0;
  logic [COORD_BITS-1:0] end_x = '0;
  logic [COORD_BITS-1:0] end_y = '0;
  logic [WIDTH_BITS-1:0] line_radius = '0;
  logic [COLOR_BITS-1:0] line_color = '0;
  logic                  vertex_valid;
  logic [COORD_BITS-1:0] corner_x;
  logic [COORD_BITS-1:0] corner_y;
  logic [COORD_BITS-1:0] seg_start_x;
  logic [COORD_BITS-1:0] seg_start_y;
  logic [COORD_BITS-1:0] seg_end_x;
  logic [COORD_BITS-1:0] seg_end_y;
  logic [COLOR_BITS-1:0] vertex_color;
  logic [WIDTH_BITS-1:0] vertex_width;
  logic [SLOT_BITS-1:0]  vertex_slot;
  logic                  last_vertex;

  vertex_t vertex_q[$];
  int      errors = 0;
  int      gap_pct = 0;

  wide_line_quad_expander_core u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint offset_of(input longint unsigned mag, input bit neg,
                                       input longint unsigned ext,
                                       input longint unsigned len);
    longint unsigned num, q;
    num = (mag * ext) << 10;
    q = (2 * num + len) / (2 * len);
    if (q > ext) q = ext;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v);
    longint hi, lo;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_BITS-1:0];
  endfunction

  // work out the six vertices of one segment
  task automatic predict_quad(input logic [COORD_BITS-1:0] psx, psy, pex, pey,
                              input logic [WIDTH_BITS-1:0] phw,
                              input logic [COLOR_BITS-1:0] pcol);
    longint sx, sy, ex, ey, dx, dy, ox, oy, w;
    longint unsigned ax, ay, ext, len;
    longint cxs[4], cys[4];
    int cmap[6] = '{0, 1, 2, 1, 2, 3};
    vertex_t v;
    sx = longint'($signed(psx));
    sy = longint'($signed(psy));
    ex = longint'($signed(pex));
    ey = longint'($signed(pey));
    dx = ex - sx;
    dy = ey - sy;
    w = longint'(phw);
    if (dx == 0 && dy == 0) begin
      cxs = '{sx + w, sx + w, sx - w, sx - w};
      cys = '{sy + w, sy - w, sy + w, sy - w};
    end else begin
      ext = phw + (64'd1 << FRAC_BITS);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      while (ax >= (64'd1 << 20) || ay >= (64'd1 << 20)) begin
        ax >>= 1;
        ay >>= 1;
      end
      len = int_sqrt((ax * ax + ay * ay) << 20);
      if (len == 0) len = 1;
      ox = offset_of(ax, dx < 0, ext, len);
      oy = offset_of(ay, dy < 0, ext, len);
      cxs = '{sx - ox - oy, ex + ox - oy, sx - ox + oy, ex + ox + oy};
      cys = '{sy - oy + ox, ey + oy + ox, sy - oy - ox, ey + oy - ox};
    end
    for (int k = 0; k < NUM_SLOTS; k++) begin
      v.cx = clamp_coord(cxs[cmap[k]]);
      v.cy = clamp_coord(cys[cmap[k]]);
      v.sx = psx;
      v.sy = psy;
      v.ex = pex;
      v.ey = pey;
      v.color = pcol;
      v.hw = phw;
      v.slot = SLOT_BITS'(k);
      v.last = (k == NUM_SLOTS - 1);
      vertex_q.push_back(v);
    end
  endtask

  // random gap, then one segment held until taken
  task automatic send_segment(input logic [COORD_BITS-1:0] psx, psy, pex, pey,
                              input logic [WIDTH_BITS-1:0] phw,
                              input logic [COLOR_BITS-1:0] pcol);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    start_x <= psx;
    start_y <= psy;
    end_x <= pex;
    end_y <= pey;
    line_radius <= phw;
    line_color <= pcol;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_quad(psx, psy, pex, pey, phw, pcol);
  endtask

  task automatic drain_vertices();
    start <= 1'b0;
    do @(posedge clk); while (vertex_q.size() != 0);
  endtask

  task automatic test_directed();
    logic [COORD_BITS-1:0] mx, mn;
    mx = {1'b0, {(COORD_BITS-1){1'b1}}};
    mn = {1'b1, {(COORD_BITS-1){1'b0}}};
    send_segment(0, 0, 0, 0, 0, 0);
    send_segment(0, 0, 0, 0, 16'hffff, 32'hffffffff);
    send_segment(mx, mx, mx, mx, 16'hffff, 32'h12345678);
    send_segment(mn, mn, mn, mn, 16'hffff, 32'h0);
    send_segment(mn, mn, mx, mx, 16'hffff, 32'hdeadbeef);
    send_segment(mx, mx, mn, mn, 0, 32'ha5a5a5a5);
    send_segment(mn, 0, mx, 0, 100, 32'h5a5a5a5a);
    send_segment(0, mx, 0, mn, 100, 32'h1);
    send_segment(0, 0, 1, 0, 0, 32'h2);
    send_segment(0, 0, 0, -1, 0, 32'h3);
    send_segment(5, 7, 6, 8, 16'hffff, 32'h4);
    send_segment(100, 100, 1700, 1300, 48, 32'h5);
    send_segment(-100, 50, -900, -1250, 8, 32'h6);
    send_segment(mx - 10, 0, mx, 3, 16'hffff, 32'h7);
    send_segment(mn + 10, mn, mn, mn + 20, 16'hffff, 32'h8);
    send_segment(0, 0, 3, 4, 16'h8000, 32'h9);
  endtask

  task automatic test_random(input int n);
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [WIDTH_BITS-1:0] hw;
    for (int i = 0; i < n; i++) begin
      sx = $urandom;
      sy = $urandom;
      case ($urandom_range(3))
        0: begin
          ex = $urandom;
          ey = $urandom;
        end
        1: begin
          ex = sx + COORD_BITS'($signed($urandom_range(64)) - 32);
          ey = sy + COORD_BITS'($signed($urandom_range(64)) - 32);
        end
        2: begin
          ex = sx;
          ey = sy;
        end
        default: begin
          ex = sx + COORD_BITS'($signed($urandom_range(8000)) - 4000);
          ey = sy;
          if ($urandom_range(1)) begin
            ey = ex;
            ex = sx;
            ey = sy + COORD_BITS'($signed($urandom_range(8000)) - 4000);
          end
        end
      endcase
      hw = $urandom_range(1) ? 16'($urandom_range(200)) : 16'($urandom);
      send_segment(sx, sy, ex, ey, hw, $urandom);
    end
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && vertex_valid) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: vertex with none expected, corner %h %h", $time,
                 corner_x, corner_y);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (e.cx !== corner_x) begin
          $display("%0t: corner_x exp %h got %h", $time, e.cx, corner_x); errors++;
        end
        if (e.cy !== corner_y) begin
          $display("%0t: corner_y exp %h got %h", $time, e.cy, corner_y); errors++;
        end
        if (e.sx !== seg_start_x) begin
          $display("%0t: seg_start_x exp %h got %h", $time, e.sx, seg_start_x); errors++;
        end
        if (e.sy !== seg_start_y) begin
          $display("%0t: seg_start_y exp %h got %h", $time, e.sy, seg_start_y); errors++;
        end
        if (e.ex !== seg_end_x) begin
          $display("%0t: seg_end_x exp %h got %h", $time, e.ex, seg_end_x); errors++;
        end
        if (e.ey !== seg_end_y) begin
          $display("%0t: seg_end_y exp %h got %h", $time, e.ey, seg_end_y); errors++;
        end
        if (e.color !== vertex_color) begin
          $display("%0t: vertex_color exp %h got %h", $time, e.color, vertex_color);
          errors++;
        end
        if (e.hw !== vertex_width) begin
          $display("%0t: vertex_width exp %h got %h", $time, e.hw, vertex_width); errors++;
        end
        if (e.slot !== vertex_slot) begin
          $display("%0t: vertex_slot exp %h got %h", $time, e.slot, vertex_slot); errors++;
        end
        if (e.last !== last_vertex) begin
          $display("%0t: last_vertex exp %h got %h", $time, e.last, last_vertex); errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain_vertices();
    gap_pct = 12;
    test_random(35);
    // sender holds off until the pipe is empty
    drain_vertices();
    gap_pct = 75;
    test_random(30);
    gap_pct = 0;
    test_random(35);
    drain_vertices();
    repeat (80) @(posedge clk);
    if (errors == 0 && vertex_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
